@@ sv/mws_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mws_pkg
// Shared constants, types and state encodings of the metric window monitor.
// -----------------------------------------------------------------------------
package mws_pkg;

   localparam int METRICS      = 4;
   localparam int WINDOW_DEPTH = 1024;
   localparam int MIDX_W       = (METRICS > 1) ? $clog2(METRICS) : 1;
   localparam int POS_W        = $clog2(WINDOW_DEPTH);
   localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
   localparam int MEM_DEPTH    = METRICS * WINDOW_DEPTH;
   localparam int ADDR_W       = $clog2(MEM_DEPTH);
   localparam int NUM_THR      = 4;
   localparam int COUNT_W      = 11;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_THR0     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THR1     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THR2     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THR3     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_EN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ALERT_EN = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FREQ     = 3'd6;

   localparam logic [62:0] FREQ_RESET  = 63'd10000000;
   localparam logic [19:0] US_PER_SEC  = 20'd1000000;
   localparam logic [63:0] LAT_LIMIT   = 64'hFFFF_FFFF_FFFF_FFFF / 64'd1000000;
   localparam logic [62:0] TIME_ONES   = '1;

   localparam int PCT_A           = 95;
   localparam int PCT_B           = 99;
   localparam int MIN_PCT_SAMPLES = 20;
   // x/100 == (x * RECIP_100) >> RECIP_SHIFT, exact for x below 1.8M
   localparam int RECIP_100   = 671089;
   localparam int RECIP_SHIFT = 26;
   localparam int X_W         = CNT_W + 7;
   localparam int KP_W        = X_W + 20;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);

   typedef enum logic [1:0] {
      OP_RECORD  = 2'd0,
      OP_LATENCY = 2'd1,
      OP_QUERY   = 2'd2,
      OP_NOP     = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      K_RECORD,
      K_QUERY,
      K_NOP
   } kind_type;

   typedef enum logic [2:0] {
      F_IDLE,
      F_MUL,
      F_SUM,
      F_DIV,
      F_DONE
   } front_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_STATS,
      B_DIVGO,
      B_MEAN,
      B_RADIX
   } back_state_type;

   typedef struct packed {
      logic [NUM_THR-1:0][63:0] thr;
      logic [NUM_THR-1:0]       thr_en;
      logic                     alert_en;
      logic [62:0]              freq;
   } cfg_type;

   typedef struct packed {
      kind_type          kind;
      logic              status;
      logic [MIDX_W-1:0] metric;
      logic [63:0]       value;
      logic [62:0]       stamp;
   } work_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_ctl_type;

   typedef struct packed {
      logic               status;
      logic               alert;
      logic [63:0]        alert_threshold;
      logic [63:0]        recorded_value;
      logic [COUNT_W-1:0] window_count;
      logic [63:0]        window_min;
      logic [63:0]        window_max;
      logic [63:0]        window_mean;
      logic [63:0]        percentile_95;
      logic [63:0]        percentile_99;
      logic [62:0]        oldest_time;
      logic [62:0]        newest_time;
   } rsp_type;

endpackage

@@ sv/mws_if.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mws_req_if / mws_rsp_if
// Valid/ready channels for monitor requests and results.
// -----------------------------------------------------------------------------
interface mws_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [2:0]  metric;
   logic [63:0] sample_value;
   logic [62:0] sample_time;
   logic [62:0] start_tick;
   logic [62:0] end_tick;

   modport source (output valid, opcode, metric, sample_value, sample_time,
                   start_tick, end_tick, input ready);
   modport sink (input valid, opcode, metric, sample_value, sample_time,
                 start_tick, end_tick, output ready);
endinterface

interface mws_rsp_if;
   logic        valid;
   logic        ready;
   logic        status;
   logic        alert;
   logic [63:0] alert_threshold;
   logic [63:0] recorded_value;
   logic [10:0] window_count;
   logic [63:0] window_min;
   logic [63:0] window_max;
   logic [63:0] window_mean;
   logic [63:0] percentile_95;
   logic [63:0] percentile_99;
   logic [62:0] oldest_time;
   logic [62:0] newest_time;

   modport source (output valid, status, alert, alert_threshold, recorded_value,
                   window_count, window_min, window_max, window_mean,
                   percentile_95, percentile_99, oldest_time, newest_time,
                   input ready);
   modport sink (input valid, status, alert, alert_threshold, recorded_value,
                 window_count, window_min, window_max, window_mean,
                 percentile_95, percentile_99, oldest_time, newest_time,
                 output ready);
endinterface

@@ sv/mws_div.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mws_div
// Restoring 64-bit unsigned divider, one quotient bit per cycle.
// -----------------------------------------------------------------------------
module mws_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [63:0]          dividend,
   input  logic [63:0]          divisor,
   output mws_pkg::div_ctl_type ctl,
   output logic [63:0]          quotient
);
   import mws_pkg::*;

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] rem_ff;
   logic [63:0] quo_ff;
   logic [63:0] dvs_ff;
   logic [64:0] shifted;
   logic [64:0] diff;

   assign shifted = {rem_ff, quo_ff[63]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         if (!diff[64]) begin
            rem_ff <= diff[63:0];
            quo_ff <= {quo_ff[62:0], 1'b1};
         end else begin
            rem_ff <= shifted[63:0];
            quo_ff <= {quo_ff[62:0], 1'b0};
         end
      end
   end

   assign ctl.busy = busy_ff;
   assign ctl.done = done_ff;
   assign quotient = quo_ff;

endmodule

@@ sv/mws_front.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mws_front
// Accepts requests, classifies them and converts latency ticks to microseconds.
// -----------------------------------------------------------------------------
module mws_front (
   input  logic              clock,
   input  logic              reset,
   input  mws_pkg::cfg_type  cfg,
   mws_req_if.sink           req_bus,
   input  logic              q_full,
   output logic              fo_valid,
   output mws_pkg::work_type fo_data
);
   import mws_pkg::*;

   front_state_type state_ff, state_in;
   logic            fo_valid_ff;
   work_type        fo_ff;
   work_type        hold_ff;
   work_type        item;
   work_type        done_item;
   logic            pathb_ff;
   logic [63:0]     mul_a_ff;
   logic [51:0]     pp_lo_ff;
   logic [51:0]     pp_hi_ff;
   logic [63:0]     prod;
   logic [63:0]     res_ff;
   logic            fo_free;
   logic            accept;
   logic            bad_metric;
   logic [62:0]     delta;
   logic            lat_zero;
   logic            short_delta;
   logic            goes_long;
   logic            div_start;
   logic [63:0]     div_dividend;
   div_ctl_type     dctl;
   logic [63:0]     quotient;

   assign fo_free       = !fo_valid_ff || !q_full;
   assign req_bus.ready = (state_ff == F_IDLE) && fo_free;
   assign accept        = req_bus.valid && req_bus.ready;

   assign bad_metric  = {1'b0, req_bus.metric} >= 4'(METRICS);
   assign delta       = req_bus.end_tick - req_bus.start_tick;
   assign lat_zero    = (cfg.freq == '0) || (req_bus.end_tick <= req_bus.start_tick);
   assign short_delta = 64'(delta) <= LAT_LIMIT;
   assign goes_long   = accept && (req_bus.opcode == OP_LATENCY) && !bad_metric && !lat_zero;
   assign prod        = 64'(pp_lo_ff) + (64'(pp_hi_ff) << 32);

   always_comb begin
      item.kind   = K_NOP;
      item.status = 1'b0;
      item.metric = req_bus.metric[MIDX_W-1:0];
      item.value  = req_bus.sample_value;
      item.stamp  = req_bus.sample_time;
      case (req_bus.opcode)
         OP_RECORD:  item.kind = K_RECORD;
         OP_LATENCY: begin
            item.kind  = K_RECORD;
            item.value = '0;
         end
         OP_QUERY:   item.kind = K_QUERY;
         default:    item.kind = K_NOP;
      endcase
      if (bad_metric && (req_bus.opcode != OP_NOP)) begin
         item.kind   = K_NOP;
         item.status = 1'b1;
      end
   end

   always_comb begin
      done_item       = hold_ff;
      done_item.value = res_ff;
   end

   always_comb begin
      state_in     = state_ff;
      div_start    = 1'b0;
      div_dividend = prod;
      case (state_ff)
         F_IDLE: begin
            div_dividend = 64'(delta);
            if (goes_long) begin
               state_in  = short_delta ? F_MUL : F_DIV;
               div_start = !short_delta;
            end
         end
         F_MUL: state_in = F_SUM;
         F_SUM: begin
            if (pathb_ff) begin
               state_in = F_DONE;
            end else begin
               div_start = 1'b1;
               state_in  = F_DIV;
            end
         end
         F_DIV: begin
            if (dctl.done) begin
               state_in = pathb_ff ? F_MUL : F_DONE;
            end
         end
         F_DONE: begin
            if (fo_free) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         fo_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if ((accept && !goes_long) || (state_ff == F_DONE && fo_free)) begin
            fo_valid_ff <= 1'b1;
         end else if (!q_full) begin
            fo_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_ff  <= item;
         pathb_ff <= !short_delta;
         mul_a_ff <= 64'(delta);
      end
      if (accept && !goes_long) begin
         fo_ff <= item;
      end
      if (state_ff == F_MUL) begin
         pp_lo_ff <= 52'(mul_a_ff[31:0]) * 52'(US_PER_SEC);
         pp_hi_ff <= 52'(mul_a_ff[63:32]) * 52'(US_PER_SEC);
      end
      if (state_ff == F_SUM && pathb_ff) begin
         res_ff <= prod;
      end
      if (state_ff == F_DIV && dctl.done) begin
         if (pathb_ff) begin
            mul_a_ff <= quotient;
         end else begin
            res_ff <= quotient;
         end
      end
      if (state_ff == F_DONE && fo_free) begin
         fo_ff <= done_item;
      end
   end

   mws_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (64'(cfg.freq)),
      .ctl      (dctl),
      .quotient (quotient)
   );

   assign fo_valid = fo_valid_ff;
   assign fo_data  = fo_ff;

   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff != F_IDLE) |-> !req_bus.ready)
      else $error("front took a transaction while converting latency");
   a_div_in_div_state: assert property (@(posedge clock) disable iff (reset)
      dctl.busy |-> (state_ff == F_DIV))
      else $error("divider running outside its wait state");
   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (fo_valid_ff && q_full) |=> fo_valid_ff)
      else $error("front output dropped while queue full");

endmodule

@@ sv/mws_queue.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mws_queue
// Small FIFO of classified work between the front and back ends.
// -----------------------------------------------------------------------------
module mws_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mws_pkg::work_type push_data,
   input  logic              pop,
   output mws_pkg::work_type pop_data,
   output logic              full,
   output logic              empty
);
   import mws_pkg::*;

   work_type           slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff;
   logic [Q_PTR_W-1:0] rd_ptr_ff;
   logic [Q_PTR_W:0]   count_ff;
   logic               do_push;
   logic               do_pop;

   assign full    = count_ff == (Q_PTR_W + 1)'(Q_DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ptr_ff];

endmodule

@@ sv/mws_back.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// mws_back
// Sample rings, record path and the window statistics engine.
// -----------------------------------------------------------------------------
module mws_back (
   input  logic              clock,
   input  logic              reset,
   input  mws_pkg::cfg_type  cfg,
   input  mws_pkg::work_type w,
   input  logic              q_empty,
   output logic              q_pop,
   mws_rsp_if.source         rsp_bus
);
   import mws_pkg::*;

   logic [63:0] mem_v [MEM_DEPTH];
   logic [62:0] mem_t [MEM_DEPTH];

   back_state_type     state_ff, state_in;
   logic               out_valid_ff;
   rsp_type            out_ff;
   rsp_type            out_in;
   logic               out_load;
   logic [POS_W-1:0]   wp_ff   [METRICS];
   logic [CNT_W-1:0]   fill_ff [METRICS];

   logic               out_free;
   logic               pop;
   logic               is_query;
   logic               we;
   logic [POS_W-1:0]   pos;
   logic [CNT_W-1:0]   n_sel;
   logic [ADDR_W-1:0]  waddr;
   logic [3:0]         m4;
   logic               alert;

   logic [ADDR_W-1:0]  base_ff;
   logic [CNT_W-1:0]   n_ff;
   logic [X_W-1:0]     x95_ff;
   logic [X_W-1:0]     x99_ff;
   logic               issuing_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic               rvalid_ff;
   logic               rlast_ff;
   logic               last_issue;
   logic               start_issue;
   logic [63:0]        rd_v_ff;
   logic [62:0]        rd_t_ff;

   logic [63:0]        mn_ff, mx_ff, sum_ff, mean_ff;
   logic [62:0]        old_ff, new_ff;
   logic [5:0]         bit_ff;
   logic [63:0]        mask_ff, p1_ff, p2_ff;
   logic [CNT_W-1:0]   k1_ff, k2_ff, c1_ff, c2_ff;
   logic [CNT_W-1:0]   c1_nx, c2_nx;
   logic [63:0]        p1_nx, p2_nx;
   logic [KP_W-1:0]    kp1, kp2;
   logic               enough;

   logic               div_start;
   div_ctl_type        dctl;
   logic [63:0]        quotient;

   assign out_free  = !out_valid_ff || rsp_bus.ready;
   assign is_query  = w.kind == K_QUERY;
   assign pos       = wp_ff[w.metric];
   assign n_sel     = fill_ff[w.metric];
   assign we        = pop && (w.kind == K_RECORD);
   assign waddr     = ADDR_W'(w.metric) * ADDR_W'(WINDOW_DEPTH) + ADDR_W'(pos);
   assign m4        = 4'(w.metric);
   assign alert     = (m4 < 4'(NUM_THR)) && cfg.thr_en[m4[1:0]] && cfg.alert_en &&
                      (w.value > cfg.thr[m4[1:0]]);
   assign enough    = n_ff >= CNT_W'(MIN_PCT_SAMPLES);
   assign last_issue = issuing_ff && (idx_ff == n_ff - 1'b1);

   always_comb begin
      state_in  = state_ff;
      pop       = 1'b0;
      div_start = 1'b0;
      case (state_ff)
         B_IDLE: begin
            if (!q_empty && out_free) begin
               pop = 1'b1;
               if (is_query && n_sel != '0) begin
                  state_in = B_STATS;
               end
            end
         end
         B_STATS: if (rlast_ff) state_in = B_DIVGO;
         B_DIVGO: begin
            div_start = 1'b1;
            state_in  = B_MEAN;
         end
         B_MEAN: if (dctl.done) state_in = enough ? B_RADIX : B_IDLE;
         B_RADIX: if (rlast_ff && bit_ff == '0) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   assign q_pop = pop;

   assign start_issue = (pop && is_query && n_sel != '0) ||
                        (state_ff == B_MEAN && dctl.done && enough) ||
                        (state_ff == B_RADIX && rlast_ff && bit_ff != '0);

   assign out_load = (pop && (!is_query || n_sel == '0)) ||
                     (state_ff == B_MEAN && dctl.done && !enough) ||
                     (state_ff == B_RADIX && rlast_ff && bit_ff == '0);

   // radix select: count elements sharing the known prefix with a zero here
   always_comb begin
      c1_nx = c1_ff;
      c2_nx = c2_ff;
      if (rvalid_ff) begin
         if (((rd_v_ff ^ p1_ff) & mask_ff) == '0 && !rd_v_ff[bit_ff]) begin
            c1_nx = c1_ff + 1'b1;
         end
         if (((rd_v_ff ^ p2_ff) & mask_ff) == '0 && !rd_v_ff[bit_ff]) begin
            c2_nx = c2_ff + 1'b1;
         end
      end
      p1_nx = p1_ff;
      p2_nx = p2_ff;
      if (k1_ff >= c1_nx) p1_nx[bit_ff] = 1'b1;
      if (k2_ff >= c2_nx) p2_nx[bit_ff] = 1'b1;
   end

   assign kp1 = KP_W'(x95_ff) * KP_W'(RECIP_100);
   assign kp2 = KP_W'(x99_ff) * KP_W'(RECIP_100);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         out_valid_ff <= 1'b0;
         issuing_ff   <= 1'b0;
         rvalid_ff    <= 1'b0;
         rlast_ff     <= 1'b0;
         for (int i = 0; i < METRICS; i++) begin
            wp_ff[i]   <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (we) begin
            wp_ff[w.metric] <= (pos == POS_W'(WINDOW_DEPTH - 1)) ? '0 : pos + 1'b1;
            if (n_sel < CNT_W'(WINDOW_DEPTH)) begin
               fill_ff[w.metric] <= n_sel + 1'b1;
            end
         end
         if (start_issue) begin
            issuing_ff <= 1'b1;
         end else if (last_issue) begin
            issuing_ff <= 1'b0;
         end
         rvalid_ff <= issuing_ff;
         rlast_ff  <= last_issue;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem_v[waddr] <= w.value;
         mem_t[waddr] <= w.stamp;
      end
      rd_v_ff <= mem_v[base_ff + ADDR_W'(idx_ff[POS_W-1:0])];
      rd_t_ff <= mem_t[base_ff + ADDR_W'(idx_ff[POS_W-1:0])];
   end

   always_ff @(posedge clock) begin
      if (start_issue) begin
         idx_ff <= '0;
      end else if (issuing_ff) begin
         idx_ff <= idx_ff + 1'b1;
      end
      if (pop) begin
         base_ff <= ADDR_W'(w.metric) * ADDR_W'(WINDOW_DEPTH);
         n_ff    <= n_sel;
         x95_ff  <= X_W'(n_sel * PCT_A);
         x99_ff  <= X_W'(n_sel * PCT_B);
         mn_ff   <= '1;
         mx_ff   <= '0;
         sum_ff  <= '0;
         old_ff  <= TIME_ONES;
         new_ff  <= '0;
      end
      if (state_ff == B_STATS && rvalid_ff) begin
         sum_ff <= sum_ff + rd_v_ff;
         if (rd_v_ff < mn_ff) mn_ff <= rd_v_ff;
         if (rd_v_ff > mx_ff) mx_ff <= rd_v_ff;
         if (rd_t_ff < old_ff) old_ff <= rd_t_ff;
         if (rd_t_ff > new_ff) new_ff <= rd_t_ff;
      end
      if (state_ff == B_MEAN && dctl.done) begin
         mean_ff <= quotient;
         bit_ff  <= 6'd63;
         mask_ff <= '0;
         p1_ff   <= '0;
         p2_ff   <= '0;
         k1_ff   <= kp1[RECIP_SHIFT +: CNT_W];
         k2_ff   <= kp2[RECIP_SHIFT +: CNT_W];
         c1_ff   <= '0;
         c2_ff   <= '0;
      end
      if (state_ff == B_RADIX) begin
         if (rlast_ff) begin
            p1_ff            <= p1_nx;
            p2_ff            <= p2_nx;
            if (k1_ff >= c1_nx) k1_ff <= k1_ff - c1_nx;
            if (k2_ff >= c2_nx) k2_ff <= k2_ff - c2_nx;
            mask_ff[bit_ff]  <= 1'b1;
            bit_ff           <= bit_ff - 6'd1;
            c1_ff            <= '0;
            c2_ff            <= '0;
         end else begin
            c1_ff <= c1_nx;
            c2_ff <= c2_nx;
         end
      end
   end

   always_comb begin
      out_in = '0;
      if (state_ff == B_IDLE) begin
         out_in.status = w.status;
         if (w.kind == K_RECORD) begin
            out_in.recorded_value  = w.value;
            out_in.alert           = alert;
            out_in.alert_threshold = alert ? cfg.thr[m4[1:0]] : '0;
         end
      end else begin
         out_in.window_count = COUNT_W'(n_ff);
         out_in.window_min   = mn_ff;
         out_in.window_max   = mx_ff;
         out_in.oldest_time  = old_ff;
         out_in.newest_time  = new_ff;
         if (state_ff == B_MEAN) begin
            out_in.window_mean   = quotient;
            out_in.percentile_95 = mx_ff;
            out_in.percentile_99 = mx_ff;
         end else begin
            out_in.window_mean   = mean_ff;
            out_in.percentile_95 = p1_nx;
            out_in.percentile_99 = p2_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   mws_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (64'(n_ff)),
      .ctl      (dctl),
      .quotient (quotient)
   );

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.status          = out_ff.status;
   assign rsp_bus.alert           = out_ff.alert;
   assign rsp_bus.alert_threshold = out_ff.alert_threshold;
   assign rsp_bus.recorded_value  = out_ff.recorded_value;
   assign rsp_bus.window_count    = out_ff.window_count;
   assign rsp_bus.window_min      = out_ff.window_min;
   assign rsp_bus.window_max      = out_ff.window_max;
   assign rsp_bus.window_mean     = out_ff.window_mean;
   assign rsp_bus.percentile_95   = out_ff.percentile_95;
   assign rsp_bus.percentile_99   = out_ff.percentile_99;
   assign rsp_bus.oldest_time     = out_ff.oldest_time;
   assign rsp_bus.newest_time     = out_ff.newest_time;

   a_query_no_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff != B_IDLE) |-> !out_valid_ff)
      else $error("result pending during a window walk");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff[0] <= CNT_W'(WINDOW_DEPTH))
      else $error("fill level beyond window depth");
   a_div_in_mean: assert property (@(posedge clock) disable iff (reset)
      dctl.busy |-> (state_ff == B_MEAN))
      else $error("mean divider running outside mean state");
   a_read_in_walk: assert property (@(posedge clock) disable iff (reset)
      rvalid_ff |-> (state_ff == B_STATS || state_ff == B_RADIX))
      else $error("window read data outside a walk");

endmodule

@@ sv/metric_window_stats_monitor.sv @@
`timescale 1ns / 1ps
// Sample records pass front output reg, queue, result reg; one per cycle while rsp ready.
// Latency records also pass the front multiplier and divider, request input held off.
// Query: a min/max/sum walk over the window, then the mean divider, and,
//   with n >= 20, 64 radix passes over the window via the single memory read port.
// Reset: synchronous, clears control, ring positions and fill levels; CSRs to defaults.
// -----------------------------------------------------------------------------
// metric_window_stats_monitor
// Per-metric sample windows with threshold alerts, latency recording and stats.
// -----------------------------------------------------------------------------
module metric_window_stats_monitor (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [mws_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mws_pkg::CSR_DATA_W-1:0]  csr_wdata,
   mws_req_if.sink                         req_bus,
   mws_rsp_if.source                       rsp_bus
);
   import mws_pkg::*;

   cfg_type  cfg_ff;
   logic     fo_valid;
   work_type fo_data;
   work_type q_data;
   logic     q_full;
   logic     q_empty;
   logic     q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.thr      <= '0;
         cfg_ff.thr_en   <= '0;
         cfg_ff.alert_en <= 1'b0;
         cfg_ff.freq     <= FREQ_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_THR0:     cfg_ff.thr[0]   <= csr_wdata;
            CSR_THR1:     cfg_ff.thr[1]   <= csr_wdata;
            CSR_THR2:     cfg_ff.thr[2]   <= csr_wdata;
            CSR_THR3:     cfg_ff.thr[3]   <= csr_wdata;
            CSR_THR_EN:   cfg_ff.thr_en   <= csr_wdata[NUM_THR-1:0];
            CSR_ALERT_EN: cfg_ff.alert_en <= csr_wdata[0];
            CSR_FREQ:     cfg_ff.freq     <= csr_wdata[62:0];
            default:      ;
         endcase
      end
   end

   mws_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_bus  (req_bus),
      .q_full   (q_full),
      .fo_valid (fo_valid),
      .fo_data  (fo_data)
   );

   mws_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fo_valid),
      .push_data (fo_data),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   mws_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .w       (q_data),
      .q_empty (q_empty),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

endmodule

@@ sim/metric_window_stats_monitor_test.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// metric_window_stats_monitor_test
// Drives record, latency and query transactions through the monitor, with
// bursty requests, a stalling receiver and several register settings, and
// checks every result against a scoreboard that tracks each metric's ring.
// -----------------------------------------------------------------------------
module metric_window_stats_monitor_test;
   import mws_pkg::*;

   localparam int CYCLE_LIMIT = 4000000;

   typedef struct {
      logic [1:0]  op;
      logic [2:0]  metric;
      logic [63:0] value;
      logic [62:0] stamp;
      logic [62:0] start_t;
      logic [62:0] end_t;
   } req_item_type;

   class mws_scoreboard;
      logic [63:0] thr[NUM_THR];
      logic [3:0]  thr_en;
      logic        alert_en;
      logic [62:0] freq;
      logic [63:0] vals[METRICS][WINDOW_DEPTH];
      logic [62:0] stamps[METRICS][WINDOW_DEPTH];
      int          wpos[METRICS];
      int          fill[METRICS];
      rsp_type     expected_q[$];
      int          errors;

      function new();
         foreach (thr[i]) thr[i] = '0;
         thr_en   = '0;
         alert_en = 1'b0;
         freq     = FREQ_RESET;
         foreach (wpos[i]) begin
            wpos[i] = 0;
            fill[i] = 0;
         end
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] data);
         case (idx)
            CSR_THR0, CSR_THR1, CSR_THR2, CSR_THR3: thr[idx] = data;
            CSR_THR_EN:   thr_en   = data[3:0];
            CSR_ALERT_EN: alert_en = data[0];
            CSR_FREQ:     freq     = data[62:0];
            default: ;
         endcase
      endfunction

      function logic [63:0] to_usec(logic [62:0] s, logic [62:0] e);
         logic [63:0] delta;
         logic [63:0] f;
         f = {1'b0, freq};
         if (f == 0 || e <= s) return '0;
         delta = {1'b0, e} - {1'b0, s};
         if (delta <= LAT_LIMIT) return (delta * 64'd1000000) / f;
         return (delta / f) * 64'd1000000;
      endfunction

      function void note_request(req_item_type r);
         rsp_type     e;
         int          m, n, idx;
         logic [63:0] v, sum, mn, mx;
         logic [62:0] oldest, newest;
         logic [63:0] sorted[$];
         e = '0;
         m = r.metric;
         if (r.op == OP_NOP) begin
         end else if (m >= METRICS) begin
            e.status = 1'b1;
         end else if (r.op == OP_RECORD || r.op == OP_LATENCY) begin
            v = (r.op == OP_RECORD) ? r.value : to_usec(r.start_t, r.end_t);
            vals[m][wpos[m]]   = v;
            stamps[m][wpos[m]] = r.stamp;
            wpos[m] = (wpos[m] + 1) % WINDOW_DEPTH;
            if (fill[m] < WINDOW_DEPTH) fill[m]++;
            e.recorded_value = v;
            if (m < NUM_THR && thr_en[m] && v > thr[m] && alert_en) begin
               e.alert           = 1'b1;
               e.alert_threshold = thr[m];
            end
         end else begin
            n = fill[m];
            if (n > 0) begin
               sum = '0; mn = '1; mx = '0; oldest = '1; newest = '0;
               for (int i = 0; i < n; i++) begin
                  idx = (wpos[m] + WINDOW_DEPTH - n + i) % WINDOW_DEPTH;
                  v = vals[m][idx];
                  sorted.push_back(v);
                  sum += v;
                  if (v < mn) mn = v;
                  if (v > mx) mx = v;
                  if (stamps[m][idx] < oldest) oldest = stamps[m][idx];
                  if (stamps[m][idx] > newest) newest = stamps[m][idx];
               end
               sorted.sort();
               e.window_count = n[COUNT_W-1:0];
               e.window_min   = mn;
               e.window_max   = mx;
               e.window_mean  = sum / n;
               if (n >= MIN_PCT_SAMPLES) begin
                  e.percentile_95 = sorted[(n * PCT_A / 100) % WINDOW_DEPTH];
                  e.percentile_99 = sorted[(n * PCT_B / 100) % WINDOW_DEPTH];
               end else begin
                  e.percentile_95 = mx;
                  e.percentile_99 = mx;
               end
               e.oldest_time = oldest;
               e.newest_time = newest;
            end
         end
         expected_q.push_back(e);
      endfunction

      function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
         if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %h", $time, got);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         cmp("status", e.status, got.status);
         cmp("alert", e.alert, got.alert);
         cmp("alert_threshold", e.alert_threshold, got.alert_threshold);
         cmp("recorded_value", e.recorded_value, got.recorded_value);
         cmp("window_count", e.window_count, got.window_count);
         cmp("window_min", e.window_min, got.window_min);
         cmp("window_max", e.window_max, got.window_max);
         cmp("window_mean", e.window_mean, got.window_mean);
         cmp("percentile_95", e.percentile_95, got.percentile_95);
         cmp("percentile_99", e.percentile_99, got.percentile_99);
         cmp("oldest_time", e.oldest_time, got.oldest_time);
         cmp("newest_time", e.newest_time, got.newest_time);
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    cycles;
   mws_scoreboard         sb;

   mws_req_if req();
   mws_rsp_if rsp();

   metric_window_stats_monitor u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req),
      .rsp_bus   (rsp)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver stall pattern: cycles through four ready styles
   always @(posedge clock) begin
      cycles <= cycles + 1;
      case ((cycles >> 8) % 4)
         0: rsp.ready <= 1'b1;
         1: rsp.ready <= ($urandom_range(0, 1) == 1);
         2: rsp.ready <= (cycles % 7) > 1;
         default: rsp.ready <= ($urandom_range(0, 9) != 0);
      endcase
      if (cycles > CYCLE_LIMIT) begin
         $display("metric_window_stats_monitor_test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.status          = rsp.status;
         got.alert           = rsp.alert;
         got.alert_threshold = rsp.alert_threshold;
         got.recorded_value  = rsp.recorded_value;
         got.window_count    = rsp.window_count;
         got.window_min      = rsp.window_min;
         got.window_max      = rsp.window_max;
         got.window_mean     = rsp.window_mean;
         got.percentile_95   = rsp.percentile_95;
         got.percentile_99   = rsp.percentile_99;
         got.oldest_time     = rsp.oldest_time;
         got.newest_time     = rsp.newest_time;
         sb.check_result(got);
      end
   end

   task automatic send_req(req_item_type r);
      req.valid        <= 1'b1;
      req.opcode       <= r.op;
      req.metric       <= r.metric;
      req.sample_value <= r.value;
      req.sample_time  <= r.stamp;
      req.start_tick   <= r.start_t;
      req.end_tick     <= r.end_t;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_request(r);
   endtask

   // send then maybe end the burst with an idle gap
   task automatic send_paced(req_item_type r);
      send_req(r);
      if ($urandom_range(0, 7) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [63:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.write_reg(idx, data);
   endtask

   task automatic end_csr();
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_q.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic req_item_type make_item(logic [1:0] op, logic [2:0] m, logic [63:0] v,
                                              logic [62:0] t, logic [62:0] s,
                                              logic [62:0] e);
      req_item_type r;
      r.op = op; r.metric = m; r.value = v; r.stamp = t; r.start_t = s; r.end_t = e;
      return r;
   endfunction

   function automatic req_item_type rand_item();
      req_item_type r;
      int           k;
      logic [62:0]  d;
      r.stamp   = 63'(rand64());
      r.start_t = 63'(rand64());
      r.end_t   = 63'(rand64());
      k = $urandom_range(0, 9);
      r.value = (k < 4) ? rand64() : (k < 8) ? 64'($urandom_range(0, 5000))
              : (k == 8) ? '1 : '0;
      k = $urandom_range(0, 99);
      r.op = (k < 60) ? OP_RECORD : (k < 93) ? OP_LATENCY : (k < 96) ? OP_QUERY : OP_NOP;
      r.metric = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(4, 7))
                                               : 3'($urandom_range(0, 3));
      if (r.op == OP_LATENCY) begin
         k = $urandom_range(0, 3);
         d = (k == 0) ? 63'($urandom_range(0, 100000000)) : 63'({$urandom, $urandom});
         if (k == 1) d = d >> $urandom_range(0, 40);
         r.start_t = r.start_t >> 1;
         r.end_t   = (k == 3) ? r.start_t - d[20:0] : r.start_t + (d >> 1);
      end
      return r;
   endfunction

   initial begin
      reset            = 1'b1;
      csr_wr_en        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      req.valid        = 1'b0;
      req.opcode       = '0;
      req.metric       = '0;
      req.sample_value = '0;
      req.sample_time  = '0;
      req.start_tick   = '0;
      req.end_tick     = '0;
      #1;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, invalid metric, no-op opcode, latency cases
      send_paced(make_item(OP_QUERY, 0, '0, '0, '0, '0));
      send_paced(make_item(OP_RECORD, 0, '0, '0, '0, '0));
      send_paced(make_item(OP_RECORD, 0, '1, '1, '1, '1));
      send_paced(make_item(OP_RECORD, 0, 64'h8000_0000_0000_0001, 63'd5, '0, '0));
      send_paced(make_item(OP_QUERY, 0, '0, '0, '0, '0));
      send_paced(make_item(OP_RECORD, 4, 64'd7, 63'd1, '0, '0));
      send_paced(make_item(OP_QUERY, 7, '0, '0, '0, '0));
      send_paced(make_item(OP_LATENCY, 5, '0, '0, '0, 63'd100));
      send_paced(make_item(OP_NOP, 1, '1, '1, '1, '1));
      send_paced(make_item(OP_LATENCY, 1, '0, 63'd9, 63'd100, 63'd12345));
      send_paced(make_item(OP_LATENCY, 1, '0, 63'd9, 63'd500, 63'd500));
      send_paced(make_item(OP_LATENCY, 1, '0, 63'd9, 63'd501, 63'd500));
      send_paced(make_item(OP_LATENCY, 1, '0, 63'd9, '0, '1));
      send_paced(make_item(OP_LATENCY, 1, '0, 63'd9, 63'd3, 63'd18446744073713));
      send_paced(make_item(OP_QUERY, 1, '0, '0, '0, '0));
      for (int i = 0; i < 22; i++)
         send_paced(make_item(OP_RECORD, 3, 64'($urandom_range(0, 30)), 63'(i * 3), '0, '0));
      send_paced(make_item(OP_QUERY, 3, '0, '0, '0, '0));
      drain();
      write_csr(CSR_FREQ, '0);
      end_csr();
      send_paced(make_item(OP_LATENCY, 2, '0, 63'd1, 63'd1, 63'd1000));
      drain();

      // random phases, each under its own register setting
      for (int ph = 0; ph < 4; ph++) begin
         for (int i = 0; i < NUM_THR; i++)
            write_csr(CSR_IDX_W'(i), (ph == 0) ? 64'd0 : (ph == 1) ? '1
                                     : (ph == 2) ? rand64() : 64'($urandom_range(0, 3000)));
         write_csr(CSR_THR_EN, (ph == 1) ? 64'd0 : (ph == 3) ? 64'hF : 64'($urandom));
         write_csr(CSR_ALERT_EN, (ph == 3) ? 64'd0 : 64'd1 | {$urandom, 1'b0});
         write_csr(CSR_FREQ, (ph == 0) ? 64'd1 : (ph == 1) ? 64'h7FFF_FFFF_FFFF_FFFF
                             : (ph == 2) ? 64'($urandom_range(1, 100000000)) : rand64());
         end_csr();
         for (int i = 0; i < 215; i++) send_paced(rand_item());
         drain();
      end
      repeat (100) @(posedge clock);

      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("metric_window_stats_monitor_test passed");
      end else begin
         $display("metric_window_stats_monitor_test failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/mws_pkg.sv
sv/mws_if.sv
sv/mws_div.sv
sv/mws_front.sv
sv/mws_queue.sv
sv/mws_back.sv
sv/metric_window_stats_monitor.sv
sim/metric_window_stats_monitor_test.sv
